// ----- rtl/core/rlws_pkg.sv -----
// Shared types and constants for the remote link watchdog and smoother.
// Holds the channel word structs, configuration register indexes and widths.
// No dependencies.
`timescale 1ns / 1ps

package rlws_pkg;

   localparam int FRAC_W   = 8;              // extra fraction bits in filter state
   localparam int CMD_W    = 16;             // command and trim width
   localparam int FILT_W   = CMD_W + FRAC_W; // filter state width
   localparam int GAIN_W   = 9;              // filter gain, Q0.8 with one headroom bit
   localparam int GAIN_SH  = 8;              // gain fraction bits
   localparam int TIME_W   = 32;
   localparam int CSR_IW   = 3;
   localparam int CSR_DW   = 16;

   localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(256);

   localparam logic [CSR_IW-1:0] CSR_FILTER_GAIN       = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_STABILIZE_TIMEOUT = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_SHUTDOWN_TIMEOUT  = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_THRUST_FLOOR      = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_THRUST_CEIL       = 3'd4;

   localparam logic ACT_PACKET = 1'b0;
   localparam logic ACT_UPDATE = 1'b1;

   typedef struct packed {
      logic                    action;
      logic [TIME_W-1:0]       time_now;
      logic [CMD_W-1:0]        target_thrust;
      logic signed [CMD_W-1:0] target_pitch;
      logic signed [CMD_W-1:0] target_roll;
      logic signed [CMD_W-1:0] target_yaw;
      logic signed [CMD_W-1:0] trim_pitch_in;
      logic signed [CMD_W-1:0] trim_roll_in;
      logic                    in_flight;
   } req_payload_type;

   typedef struct packed {
      logic [CMD_W-1:0]        out_thrust;
      logic signed [CMD_W-1:0] out_pitch;
      logic signed [CMD_W-1:0] out_roll;
      logic signed [CMD_W-1:0] out_yaw;
      logic signed [CMD_W-1:0] trim_pitch_out;
      logic signed [CMD_W-1:0] trim_roll_out;
      logic                    link_locked;
      logic                    land_request;
   } rsp_payload_type;

   typedef struct packed {
      logic [GAIN_W-1:0] filter_gain;
      logic [CMD_W-1:0]  stabilize_timeout;
      logic [CMD_W-1:0]  shutdown_timeout;
      logic [CMD_W-1:0]  thrust_floor;
      logic [CMD_W-1:0]  thrust_ceil;
   } cfg_type;

endpackage

// ----- rtl/core/rlws_csr.sv -----
// Configuration register bank for the link watchdog smoother.
// Depends on rlws_pkg for register indexes and the cfg_type struct.
`timescale 1ns / 1ps

module rlws_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rlws_pkg::CSR_IW-1:0]   csr_index,
   input  logic [rlws_pkg::CSR_DW-1:0]   csr_wdata,
   output rlws_pkg::cfg_type             cfg
);

   rlws_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rlws_pkg::CSR_FILTER_GAIN:
               cfg_in.filter_gain = csr_wdata[rlws_pkg::GAIN_W-1:0];
            rlws_pkg::CSR_STABILIZE_TIMEOUT: cfg_in.stabilize_timeout = csr_wdata;
            rlws_pkg::CSR_SHUTDOWN_TIMEOUT:  cfg_in.shutdown_timeout  = csr_wdata;
            rlws_pkg::CSR_THRUST_FLOOR:      cfg_in.thrust_floor      = csr_wdata;
            rlws_pkg::CSR_THRUST_CEIL:       cfg_in.thrust_ceil       = csr_wdata;
            default: ;  // drop writes past the last register
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_gain       <= rlws_pkg::GAIN_W'(51);
         cfg_ff.stabilize_timeout <= rlws_pkg::CMD_W'(500);
         cfg_ff.shutdown_timeout  <= rlws_pkg::CMD_W'(1000);
         cfg_ff.thrust_floor      <= rlws_pkg::CMD_W'(5000);
         cfg_ff.thrust_ceil       <= rlws_pkg::CMD_W'(60000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/rlws_lowpass.sv -----
// One first-order low-pass step: f + floor((target << FRAC_W - f) * gain / 256).
// Depends on rlws_pkg for widths. Purely combinational.
`timescale 1ns / 1ps

module rlws_lowpass (
   input  logic signed [rlws_pkg::FILT_W:0]   f_cur,
   input  logic signed [rlws_pkg::CMD_W:0]    target,
   input  logic [rlws_pkg::GAIN_W-1:0]        gain,
   output logic signed [rlws_pkg::FILT_W:0]   f_next
);

   localparam int DIFF_W = rlws_pkg::FILT_W + 2;
   localparam int PROD_W = DIFF_W + rlws_pkg::GAIN_W + 1;

   logic signed [DIFF_W-1:0]              diff;
   logic signed [rlws_pkg::GAIN_W:0]      gain_s;
   logic signed [PROD_W-1:0]              prod;
   logic signed [PROD_W-1:0]              step;
   logic signed [PROD_W-1:0]              sum;

   always_comb begin
      diff   = {target[rlws_pkg::CMD_W], target, {rlws_pkg::FRAC_W{1'b0}}}
               - {f_cur[rlws_pkg::FILT_W], f_cur};
      gain_s = {1'b0, gain};
      prod   = diff * gain_s;
      // arithmetic shift floors toward minus infinity
      step   = prod >>> rlws_pkg::GAIN_SH;
      sum    = step + PROD_W'(f_cur);
      f_next = sum[rlws_pkg::FILT_W:0];
   end

endmodule

// ----- rtl/core/remote_link_watchdog_smoother.sv -----
// Top level of the remote link watchdog and command smoother.
// Depends on rlws_pkg, rlws_csr and rlws_lowpass.
//
// Usage:
//   req_* carries one word per item. A packet word (action = packet) stores the
//   commanded thrust, angles and trims and stamps time_now; it gives no result.
//   An update word (action = update) checks the time since the last packet
//   against the two timeouts, steps the four low-pass filters and returns one
//   rsp_* word with the shaped commands, trims, lock flag and land request.
//   csr_* writes the five configuration registers; it is always ready. The user
//   must write it only while the block is idle; the block does not enforce this.
//   An accepted word lands in the input register; an update word's result is then
//   registered in the output register once that register is free, and rsp_valid
//   rises with it. One word is taken per cycle while the output register is not
//   stalled; the filter step between the two registers is combinational.
//   When rsp_ready is low, the output register holds its word; packet words
//   still drain, and an update word waits in the input register, so req_ready
//   drops only once both registers are full.
//   Synchronous reset empties both registers, clears all filter state, trims,
//   packet time and lock flag, and loads the register defaults.
`timescale 1ns / 1ps

module remote_link_watchdog_smoother (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rlws_pkg::req_payload_type     req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rlws_pkg::rsp_payload_type     rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rlws_pkg::CSR_IW-1:0]   csr_index,
   input  logic [rlws_pkg::CSR_DW-1:0]   csr_wdata
);

   localparam int FW = rlws_pkg::FILT_W;
   localparam int CW = rlws_pkg::CMD_W;
   localparam int FR = rlws_pkg::FRAC_W;

   rlws_pkg::cfg_type cfg;

   // input register
   logic                      s1_valid_ff, s1_valid_in;
   rlws_pkg::req_payload_type s1_data_ff;
   logic                      s1_fire, pkt_fire, upd_fire;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   rlws_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   // block state
   logic [rlws_pkg::TIME_W-1:0] last_time_ff;
   logic                        locked_ff, locked_in;
   logic [CW-1:0]               hold_thrust_ff;
   logic signed [CW-1:0]        hold_ang_ff [3];
   logic signed [CW-1:0]        hold_trim_ff [2];
   logic [FW-1:0]               thr_filt_ff, thr_filt_in;
   logic signed [FW-1:0]        ang_filt_ff [3];
   logic signed [FW-1:0]        ang_filt_in [3];
   logic signed [CW-1:0]        trim_ff [2];
   logic signed [CW-1:0]        trim_in [2];

   // datapath
   logic [rlws_pkg::TIME_W-1:0] elapsed;
   logic                        land;
   logic [rlws_pkg::GAIN_W-1:0] gain_eff;
   logic [FW-1:0]               thr_base;
   logic signed [FW-1:0]        ang_base [3];
   logic signed [FW:0]          thr_lp;
   logic signed [FW:0]          ang_lp [3];
   logic [FW-1:0]               thr_lo, thr_hi;

   rlws_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign gain_eff = (cfg.filter_gain > rlws_pkg::GAIN_MAX) ? rlws_pkg::GAIN_MAX
                                                            : cfg.filter_gain;

   rlws_lowpass u_lp_thrust (
      .f_cur  ({1'b0, thr_base}),
      .target ({1'b0, hold_thrust_ff}),
      .gain   (gain_eff),
      .f_next (thr_lp)
   );

   for (genvar a = 0; a < 3; a++) begin : g_ang
      rlws_lowpass u_lp_ang (
         .f_cur  ({ang_base[a][FW-1], ang_base[a]}),
         .target ({hold_ang_ff[a][CW-1], hold_ang_ff[a]}),
         .gain   (gain_eff),
         .f_next (ang_lp[a])
      );
   end

   // handshake: packet words always drain, update words need a free output slot
   assign s1_fire   = s1_valid_ff &&
                      (s1_data_ff.action == rlws_pkg::ACT_PACKET || !rsp_valid_ff || rsp_ready);
   assign pkt_fire  = s1_fire && (s1_data_ff.action == rlws_pkg::ACT_PACKET);
   assign upd_fire  = s1_fire && (s1_data_ff.action == rlws_pkg::ACT_UPDATE);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !s1_fire);
      rsp_valid_in = upd_fire || (rsp_valid_ff && !rsp_ready);
   end

   always_comb begin
      elapsed   = s1_data_ff.time_now - last_time_ff;
      land      = 1'b0;
      locked_in = locked_ff;
      thr_base  = thr_filt_ff;
      for (int i = 0; i < 3; i++) ang_base[i] = ang_filt_ff[i];

      priority if (elapsed < {16'b0, cfg.stabilize_timeout}) begin
         locked_in = 1'b0;
      end else if (elapsed < {16'b0, cfg.shutdown_timeout}) begin
         for (int i = 0; i < 3; i++) ang_base[i] = '0;
      end else begin
         locked_in = 1'b1;
         for (int i = 0; i < 3; i++) ang_base[i] = '0;
         thr_base  = '0;
         land      = s1_data_ff.in_flight;
      end

      thr_lo = {cfg.thrust_floor, {FR{1'b0}}};
      thr_hi = {cfg.thrust_ceil, {FR{1'b0}}};

      if (!locked_in) begin
         // dead zone first, then clamp
         priority if (thr_lp[FW-1:0] < thr_lo) begin
            thr_filt_in = '0;
         end else if (thr_lp[FW-1:0] >= thr_hi) begin
            thr_filt_in = thr_hi;
         end else begin
            thr_filt_in = thr_lp[FW-1:0];
         end
         for (int i = 0; i < 3; i++) ang_filt_in[i] = ang_lp[i][FW-1:0];
         for (int i = 0; i < 2; i++) trim_in[i] = hold_trim_ff[i];
      end else begin
         thr_filt_in = thr_base;
         for (int i = 0; i < 3; i++) ang_filt_in[i] = ang_base[i];
         for (int i = 0; i < 2; i++) trim_in[i] = trim_ff[i];
      end

      rsp_data_in.out_thrust     = thr_filt_in[FW-1:FR];
      rsp_data_in.out_pitch      = ang_filt_in[0][FW-1:FR];
      rsp_data_in.out_roll       = ang_filt_in[1][FW-1:FR];
      rsp_data_in.out_yaw        = ang_filt_in[2][FW-1:FR];
      rsp_data_in.trim_pitch_out = trim_in[0];
      rsp_data_in.trim_roll_out  = trim_in[1];
      rsp_data_in.link_locked    = locked_in;
      rsp_data_in.land_request   = land;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         last_time_ff   <= '0;
         locked_ff      <= 1'b0;
         hold_thrust_ff <= '0;
         thr_filt_ff    <= '0;
         for (int i = 0; i < 3; i++) begin
            hold_ang_ff[i] <= '0;
            ang_filt_ff[i] <= '0;
         end
         for (int i = 0; i < 2; i++) begin
            hold_trim_ff[i] <= '0;
            trim_ff[i]      <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pkt_fire) begin
            last_time_ff    <= s1_data_ff.time_now;
            hold_thrust_ff  <= s1_data_ff.target_thrust;
            hold_ang_ff[0]  <= s1_data_ff.target_pitch;
            hold_ang_ff[1]  <= s1_data_ff.target_roll;
            hold_ang_ff[2]  <= s1_data_ff.target_yaw;
            hold_trim_ff[0] <= s1_data_ff.trim_pitch_in;
            hold_trim_ff[1] <= s1_data_ff.trim_roll_in;
         end
         if (upd_fire) begin
            locked_ff   <= locked_in;
            thr_filt_ff <= thr_filt_in;
            for (int i = 0; i < 3; i++) ang_filt_ff[i] <= ang_filt_in[i];
            for (int i = 0; i < 2; i++) trim_ff[i] <= trim_in[i];
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (upd_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
